// ----- hdl/kvt_pkg.sv -----
package kvt_pkg;

  localparam int unsigned KeyW = 32;
  localparam int unsigned ValW = 64;

  typedef enum logic [1:0] {
    STATUS_INSERTED  = 2'd0,
    STATUS_FOUND     = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_FULL      = 2'd3
  } status_e;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic [ValW-1:0]        value;
  } entry_t;

endpackage

// ----- hdl/kvt_store.sv -----
module kvt_store #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  kvt_pkg::entry_t      wdata_i,
  input  logic [AddrW-1:0]     raddr_i,
  output kvt_pkg::entry_t      rdata_o
);

  kvt_pkg::entry_t mem_q [Depth];
  kvt_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/key_value_table_newest_match.sv -----
// Key-value table with newest-match search.
// A request on the input channel either inserts a key and a 64-bit value as
// the newest entry or searches the stored entries for a key. Every request
// produces exactly one response with a status and, on a match, the key and value.
// An insert, or a search of an empty table, goes straight to the response
// state. A search reads one entry per cycle from the entry memory, newest
// first, until an entry matches or the oldest entry has been read. The entry
// memory has a single read port.
// One request is in flight at a time; the next request is accepted in the
// cycle after the previous response has moved into the output register.
// An insert into a full table is dropped and answered with the full status.
// Reset clears the entry count, so the table is empty afterwards; the
// memory contents are not cleared, and a search compares only written entries.
// When the receiver stalls, the response waits in the output register, one
// further response waits in the block, and then input ready stays low.
module key_value_table_newest_match #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                opcode_i,
  input  logic signed [kvt_pkg::KeyW-1:0]     key_i,
  input  logic [kvt_pkg::ValW-1:0]            value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          status_o,
  output logic signed [kvt_pkg::KeyW-1:0]     found_key_o,
  output logic [kvt_pkg::ValW-1:0]            found_value_o
);

  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  kvt_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [AddrW-1:0] ptr_q, ptr_d;
  logic signed [kvt_pkg::KeyW-1:0] req_key_q;

  kvt_pkg::status_e res_status_q, res_status_d;
  kvt_pkg::entry_t  res_entry_q, res_entry_d;

  logic             out_valid_q;
  kvt_pkg::status_e out_status_q;
  kvt_pkg::entry_t  out_entry_q;

  logic             accept;
  logic             is_search;
  logic             full;
  logic             match;
  logic             out_free;
  logic             mem_we;
  logic             res_load;
  logic             out_load;
  logic [CntW-1:0]  cnt_m1;
  logic [AddrW-1:0] raddr;
  kvt_pkg::entry_t  wdata;
  kvt_pkg::entry_t  rdata;

  assign accept    = in_valid_i && in_ready_o;
  assign is_search = (opcode_i == kvt_pkg::OP_SEARCH);
  assign full      = (count_q == CntW'(DEPTH));
  assign cnt_m1    = count_q - CntW'(1);
  assign match     = (rdata.key == req_key_q);
  assign out_free  = !out_valid_q || out_ready_i;
  assign wdata     = '{key: key_i, value: value_i};

  kvt_store #(
    .Depth (DEPTH),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      kvt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (is_search && (count_q != '0)) begin
            state_d = kvt_pkg::ST_SCAN;
          end else begin
            state_d = kvt_pkg::ST_RESP;
          end
        end
      end
      kvt_pkg::ST_SCAN: begin
        if (match || (ptr_q == '0)) begin
          state_d = kvt_pkg::ST_RESP;
        end
      end
      kvt_pkg::ST_RESP: begin
        if (out_free) begin
          state_d = kvt_pkg::ST_IDLE;
        end
      end
      default: state_d = kvt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    mem_we       = 1'b0;
    res_load     = 1'b0;
    out_load     = 1'b0;
    raddr        = ptr_q - AddrW'(1);
    ptr_d        = ptr_q;
    count_d      = count_q;
    res_status_d = kvt_pkg::STATUS_NOT_FOUND;
    res_entry_d  = '0;
    case (state_q)
      kvt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        raddr      = cnt_m1[AddrW-1:0];
        if (in_valid_i) begin
          ptr_d = cnt_m1[AddrW-1:0];
          if (!is_search) begin
            res_load = 1'b1;
            if (full) begin
              res_status_d = kvt_pkg::STATUS_FULL;
            end else begin
              mem_we       = 1'b1;
              count_d      = count_q + CntW'(1);
              res_status_d = kvt_pkg::STATUS_INSERTED;
            end
          end else if (count_q == '0) begin
            res_load = 1'b1;
          end
        end
      end
      kvt_pkg::ST_SCAN: begin
        if (match) begin
          res_load     = 1'b1;
          res_status_d = kvt_pkg::STATUS_FOUND;
          res_entry_d  = rdata;
        end else if (ptr_q == '0) begin
          res_load = 1'b1;
        end else begin
          ptr_d = ptr_q - AddrW'(1);
        end
      end
      kvt_pkg::ST_RESP: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kvt_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (accept) begin
      req_key_q <= key_i;
    end
    if (res_load) begin
      res_status_q <= res_status_d;
      res_entry_q  <= res_entry_d;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_entry_q  <= res_entry_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_key_o   = out_entry_q.key;
  assign found_value_o = out_entry_q.value;

endmodule

// ----- hdl/kvt_checker.sv -----
module kvt_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            opcode_i,
  input logic signed [kvt_pkg::KeyW-1:0] key_i,
  input logic [kvt_pkg::ValW-1:0]        value_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [1:0]                      status_o,
  input logic signed [kvt_pkg::KeyW-1:0] found_key_o,
  input logic [kvt_pkg::ValW-1:0]        found_value_o
);

  // A stalled response stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(status_o) && $stable(found_key_o) &&
       $stable(found_value_o)))
    else $error("stalled response changed");

  // Only a found response carries a key and a value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != kvt_pkg::STATUS_FOUND)) |->
      ((found_key_o == '0) && (found_value_o == '0)))
    else $error("non-found response carries data");

  // One request is in flight at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while another is in flight");

endmodule

bind key_value_table_newest_match kvt_checker u_kvt_checker (.*);
